// File: sv/hlpm_pkg.sv
package hlpm_pkg;

   localparam int MV_W    = 12;
   localparam int RUN_W   = 11;
   localparam int TICK_W  = 4;
   localparam int COUNT_W = 8;
   localparam int CSR_IDX_W = 3;

   localparam int LOAD_MAX = 4095;

   localparam logic [RUN_W-1:0]   EMPTY_RUN_FLAG = 11'd20;
   localparam logic [RUN_W-1:0]   EMPTY_RUN_CAP  = 11'd2000;
   localparam logic [TICK_W-1:0]  TICK_MAX       = 4'd15;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

   localparam int EMPTY_THR_RESET = 200;
   localparam logic [TICK_W-1:0]  EMPTY_TICK_LIMIT_RESET = 4'd12;
   localparam logic [MV_W-1:0]    OT_THR_RESET           = 12'd692;
   localparam logic [COUNT_W-1:0] OT_COUNT_RESET         = 8'd10;
   localparam logic [MV_W-1:0]    OC_LIMIT_RESET         = 12'd2900;
   localparam logic [COUNT_W-1:0] OC_COUNT_RESET         = 8'd3;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EMPTY_THR   = 3'd0,
      CSR_EMPTY_TICKS = 3'd1,
      CSR_OT_THR      = 3'd2,
      CSR_OT_COUNT    = 3'd3,
      CSR_OC_LIMIT    = 3'd4,
      CSR_OC_COUNT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic take;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic empty_flag;
      logic overcurrent_shutdown;
      logic overtemp_shutdown;
      logic empty_shutdown;
   } flags_type;

endpackage

// File: sv/hlpm_window.sv
module hlpm_window
   import hlpm_pkg::*;
#(
   parameter int WINDOW_LEN = 20,
   parameter int SUM_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  win_ctrl_type     ctrl,
   input  logic [MV_W-1:0]  load_mv,
   output logic [SUM_W-1:0] sum_out
);

   localparam int POS_W = $clog2(WINDOW_LEN);

   logic [MV_W-1:0]       mem [WINDOW_LEN];
   logic [MV_W-1:0]       rdata_ff;
   logic [WINDOW_LEN-1:0] valid_ff, valid_in;
   logic [MV_W-1:0]       base_ff, base_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  primed_ff, primed_in;
   logic [MV_W-1:0]       old_val;
   logic [SUM_W-1:0]      prime_sum;

   // slots not written since the last fill read as the fill value
   assign old_val   = valid_ff[pos_ff] ? rdata_ff : base_ff;
   assign prime_sum = SUM_W'(load_mv) * SUM_W'(WINDOW_LEN);

   always_comb begin
      valid_in  = valid_ff;
      base_in   = base_ff;
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      primed_in = primed_ff;
      if (ctrl.clear) begin
         valid_in = '0;
         base_in  = '0;
         sum_in   = '0;
      end else if (ctrl.take) begin
         primed_in = 1'b1;
         pos_in    = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;
         if (!primed_ff) begin
            valid_in         = '0;
            valid_in[pos_ff] = 1'b1;
            base_in          = load_mv;
            sum_in           = prime_sum;
         end else begin
            valid_in[pos_ff] = 1'b1;
            sum_in           = sum_ff - SUM_W'(old_val) + SUM_W'(load_mv);
         end
      end
   end

   assign sum_out = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         base_ff   <= '0;
         sum_ff    <= '0;
         pos_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         base_ff   <= base_in;
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         primed_ff <= primed_in;
      end
   end

   // write current slot, prefetch the slot used by the next word
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         mem[pos_ff] <= load_mv;
      end
      rdata_ff <= mem[pos_in];
   end

endmodule

// File: sv/hlpm_out.sv
module hlpm_out
   import hlpm_pkg::*;
#(
   parameter int WINDOW_LEN = 20,
   parameter int SUM_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  flags_type        in_flags,
   input  logic [SUM_W-1:0] in_sum,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata
);

   // divide by the window length through a reciprocal multiply
   localparam int DIV_L  = $clog2(WINDOW_LEN);
   localparam int DIV_S  = SUM_W + DIV_L;
   localparam int M_W    = SUM_W + 1;
   localparam int PROD_W = SUM_W + M_W;
   localparam longint unsigned DIV_NUM =
      (64'd1 << DIV_S) + 64'(WINDOW_LEN) - 64'd1;
   localparam logic [M_W-1:0] DIV_M = M_W'(DIV_NUM / 64'(WINDOW_LEN));

   logic              valid_ff;
   flags_type         flags_ff;
   logic [MV_W-1:0]   avg_ff, avg_in;
   logic [PROD_W-1:0] prod;

   assign prod     = PROD_W'(in_sum) * PROD_W'(DIV_M);
   assign avg_in   = prod[DIV_S +: MV_W];
   assign in_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         flags_ff <= in_flags;
         avg_ff   <= avg_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {flags_ff.empty_flag, avg_ff, flags_ff.overcurrent_shutdown,
                        flags_ff.overtemp_shutdown, flags_ff.empty_shutdown};

endmodule

// File: sv/heater_load_protection_monitor_top.sv
// Each req word passes through the input, update and average stages, which each hold a word.
// Throughput: one word per cycle, as long as rsp_tready does not hold the output back.
// The window update and counter checks finish in the update stage; the average
// is a reciprocal multiply in the output stage.
// Reset (synchronous, active high) empties the pipeline, zeroes the window and
// counters and loads the register defaults; no clearing pass is needed.
module heater_load_protection_monitor_top
   import hlpm_pkg::*;
#(
   parameter int WINDOW_LEN = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,  // load_mv, temp_mv, preheat_done, heater_on
   input  logic                 req_tuser,  // kind
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // empty_shutdown, overtemp_shutdown,
                                            // overcurrent_shutdown, load_average, empty_flag
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MV_W-1:0]      csr_wdata
);

   localparam int SUM_W = $clog2(LOAD_MAX * WINDOW_LEN + 1);

   // config
   logic [SUM_W-1:0]   empty_thr_w_ff;
   logic [TICK_W-1:0]  empty_tick_limit_ff;
   logic [MV_W-1:0]    ot_thr_ff;
   logic [COUNT_W-1:0] ot_count_ff;
   logic [MV_W-1:0]    oc_limit_ff;
   logic [COUNT_W-1:0] oc_count_ff;

   // input stage
   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic [MV_W-1:0]    s1_load_ff;
   logic [MV_W-1:0]    s1_temp_ff;
   logic               s1_preheat_ff;
   logic               s1_heater_ff;

   // update stage
   logic               s2_valid_ff;
   flags_type          s2_flags_ff, s2_flags_in;
   logic [SUM_W-1:0]   s2_sum_ff;

   // counters
   logic [RUN_W-1:0]   er_ff, er_in, er_base;
   logic [TICK_W-1:0]  ticks_ff, ticks_in, tick_step;
   logic [COUNT_W-1:0] hot_ff, hot_in, hot_step;
   logic [COUNT_W-1:0] ovl_ff, ovl_in, ovl_step;

   logic               s2_ready, out_ready, adv;
   win_ctrl_type       win_ctrl;
   logic [SUM_W-1:0]   win_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_thr_w_ff      <= SUM_W'(EMPTY_THR_RESET * WINDOW_LEN);
         empty_tick_limit_ff <= EMPTY_TICK_LIMIT_RESET;
         ot_thr_ff           <= OT_THR_RESET;
         ot_count_ff         <= OT_COUNT_RESET;
         oc_limit_ff         <= OC_LIMIT_RESET;
         oc_count_ff         <= OC_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_EMPTY_THR: begin
               // kept pre-scaled so the empty check compares against the sum
               empty_thr_w_ff <= SUM_W'(csr_wdata) * SUM_W'(WINDOW_LEN);
            end
            CSR_EMPTY_TICKS: empty_tick_limit_ff <= csr_wdata[TICK_W-1:0];
            CSR_OT_THR:      ot_thr_ff           <= csr_wdata;
            CSR_OT_COUNT:    ot_count_ff         <= csr_wdata[COUNT_W-1:0];
            CSR_OC_LIMIT:    oc_limit_ff         <= csr_wdata;
            CSR_OC_COUNT:    oc_count_ff         <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign s2_ready   = !s2_valid_ff || out_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign adv        = s1_valid_ff && s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff    <= kind_type'(req_tuser);
         s1_load_ff    <= req_tdata[11:0];
         s1_temp_ff    <= req_tdata[23:12];
         s1_preheat_ff <= req_tdata[24];
         s1_heater_ff  <= req_tdata[25];
      end
   end

   assign tick_step = (ticks_ff < TICK_MAX) ? ticks_ff + 1'b1 : ticks_ff;
   assign hot_step  = (hot_ff < COUNT_MAX) ? hot_ff + 1'b1 : hot_ff;
   assign ovl_step  = (ovl_ff < COUNT_MAX) ? ovl_ff + 1'b1 : ovl_ff;
   assign er_base   = (er_ff > EMPTY_RUN_CAP) ? EMPTY_RUN_FLAG : er_ff;

   always_comb begin
      er_in       = er_ff;
      ticks_in    = ticks_ff;
      hot_in      = hot_ff;
      ovl_in      = ovl_ff;
      win_ctrl    = '0;
      s2_flags_in = '0;
      case (s1_kind_ff)
         KIND_TICK: begin
            if (er_ff > EMPTY_RUN_FLAG) begin
               if (tick_step >= empty_tick_limit_ff) begin
                  s2_flags_in.empty_shutdown = 1'b1;
                  win_ctrl.clear             = adv;
                  ticks_in                   = '0;
                  er_in                      = '0;
               end else begin
                  ticks_in = tick_step;
               end
            end else begin
               ticks_in = '0;
            end
         end
         KIND_SAMPLE: begin
            if (s1_preheat_ff) begin
               win_ctrl.take = adv;
               er_in = (win_sum < empty_thr_w_ff) ? er_base + 1'b1 : '0;
            end
            hot_in = (s1_temp_ff < ot_thr_ff) ? hot_step : '0;
            if (hot_in > ot_count_ff && s1_heater_ff) begin
               hot_in                        = '0;
               s2_flags_in.overtemp_shutdown = 1'b1;
            end
            if (s1_load_ff > oc_limit_ff) begin
               ovl_in                           = ovl_step;
               s2_flags_in.overcurrent_shutdown = (ovl_step > oc_count_ff);
            end else begin
               ovl_in = '0;
            end
         end
         default: ;
      endcase
      s2_flags_in.empty_flag = (er_in > EMPTY_RUN_FLAG);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         er_ff    <= '0;
         ticks_ff <= '0;
         hot_ff   <= '0;
         ovl_ff   <= '0;
      end else if (adv) begin
         er_ff    <= er_in;
         ticks_ff <= ticks_in;
         hot_ff   <= hot_in;
         ovl_ff   <= ovl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_flags_ff <= s2_flags_in;
         s2_sum_ff   <= win_sum;
      end
   end

   hlpm_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win_ctrl),
      .load_mv (s1_load_ff),
      .sum_out (win_sum)
   );

   hlpm_out #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid_ff),
      .in_ready   (out_ready),
      .in_flags   (s2_flags_ff),
      .in_sum     (s2_sum_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hlpm_pkg::*;

   localparam int WIN        = 20;
   localparam int RUN_LIMIT  = 400000;
   localparam int DRAIN_WAIT = 8;
   localparam int LONG_HOLD  = 250;

   typedef struct packed {
      logic            empty_flag;
      logic [MV_W-1:0] load_average;
      logic            overcurrent_shutdown;
      logic            overtemp_shutdown;
      logic            empty_shutdown;
   } rsp_word_type;

   typedef struct {
      kind_type        kind;
      logic [MV_W-1:0] load_mv;
      logic [MV_W-1:0] temp_mv;
      logic            preheat_done;
      logic            heater_on;
   } req_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [31:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MV_W-1:0]      csr_wdata = '0;
   wire                  req_tready;
   wire                  rsp_tvalid;
   wire  [15:0]          rsp_tdata;

   heater_load_protection_monitor_top #(.WINDOW_LEN(WIN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // load_mv, temp_mv, preheat_done, heater_on
      .req_tuser  (req_tuser),   // kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // empty_shutdown, overtemp_shutdown, overcurrent_shutdown,
                                 // load_average, empty_flag
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // register copies
   int unsigned cfg_empty_thr;
   int unsigned cfg_tick_limit;
   int unsigned cfg_ot_thr;
   int unsigned cfg_ot_count;
   int unsigned cfg_oc_limit;
   int unsigned cfg_oc_count;

   // monitor state
   int unsigned win_mv [WIN];
   int unsigned win_sum;
   int unsigned win_pos;
   bit          win_primed;
   int unsigned empty_run;
   int unsigned empty_ticks;
   int unsigned hot_run;
   int unsigned overload_run;

   rsp_word_type rsp_due[$];
   int           fail_count = 0;
   logic         no_idle = 1'b0;
   int           stall_req = 0;
   int           stall_served = 0;
   int           hold_left = 0;
   int           cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("heater_load_protection_monitor_top regression: fail");
      $finish;
   end

   task automatic reset_monitor();
      cfg_empty_thr  = EMPTY_THR_RESET;
      cfg_tick_limit = 32'(EMPTY_TICK_LIMIT_RESET);
      cfg_ot_thr     = 32'(OT_THR_RESET);
      cfg_ot_count   = 32'(OT_COUNT_RESET);
      cfg_oc_limit   = 32'(OC_LIMIT_RESET);
      cfg_oc_count   = 32'(OC_COUNT_RESET);
      foreach (win_mv[k]) win_mv[k] = 0;
      win_sum      = 0;
      win_pos      = 0;
      win_primed   = 0;
      empty_run    = 0;
      empty_ticks  = 0;
      hot_run      = 0;
      overload_run = 0;
   endtask

   function automatic rsp_word_type predict_protection(input req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.kind == KIND_TICK) begin
         if (empty_run > EMPTY_RUN_FLAG) begin
            if (empty_ticks < TICK_MAX) empty_ticks++;
            if (empty_ticks >= cfg_tick_limit) begin
               r.empty_shutdown = 1'b1;
               foreach (win_mv[k]) win_mv[k] = 0;
               win_sum     = 0;
               empty_ticks = 0;
               empty_run   = 0;
            end
         end else begin
            empty_ticks = 0;
         end
      end else begin
         if (w.preheat_done) begin
            if (!win_primed) begin
               foreach (win_mv[k]) win_mv[k] = 32'(w.load_mv);
               win_sum    = 32'(w.load_mv) * WIN;
               win_primed = 1;
            end
            win_sum         = win_sum - win_mv[win_pos] + 32'(w.load_mv);
            win_mv[win_pos] = 32'(w.load_mv);
            win_pos         = (win_pos + 1) % WIN;
            if (empty_run > EMPTY_RUN_CAP) empty_run = 32'(EMPTY_RUN_FLAG);
            if (win_sum / WIN < cfg_empty_thr) empty_run++;
            else empty_run = 0;
         end
         if (w.temp_mv < cfg_ot_thr) begin
            if (hot_run < COUNT_MAX) hot_run++;
         end else begin
            hot_run = 0;
         end
         if (hot_run > cfg_ot_count && w.heater_on) begin
            hot_run = 0;
            r.overtemp_shutdown = 1'b1;
         end
         if (w.load_mv > cfg_oc_limit) begin
            if (overload_run < COUNT_MAX) overload_run++;
            if (overload_run > cfg_oc_count) r.overcurrent_shutdown = 1'b1;
         end else begin
            overload_run = 0;
         end
      end
      r.load_average = MV_W'(win_sum / WIN);
      r.empty_flag   = empty_run > EMPTY_RUN_FLAG;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result checker and receiver backpressure
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected word expected none actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = rsp_due.pop_front();
               check_field("empty_shutdown", 32'(want.empty_shutdown),
                           32'(got.empty_shutdown));
               check_field("overtemp_shutdown", 32'(want.overtemp_shutdown),
                           32'(got.overtemp_shutdown));
               check_field("overcurrent_shutdown", 32'(want.overcurrent_shutdown),
                           32'(got.overcurrent_shutdown));
               check_field("load_average", 32'(want.load_average), 32'(got.load_average));
               check_field("empty_flag", 32'(want.empty_flag), 32'(got.empty_flag));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_served != stall_req) begin
            stall_served++;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 15);
         end
      end
   end

   task automatic send_word(input req_word_type w);
      if (!no_idle) begin
         while ($urandom_range(99) < 15) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tdata  <= {6'b0, w.heater_on, w.preheat_done, w.temp_mv, w.load_mv};
      do @(posedge clock); while (!req_tready);
      rsp_due.push_back(predict_protection(w));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[MV_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_EMPTY_THR:   cfg_empty_thr  = val & 32'hFFF;
         CSR_EMPTY_TICKS: cfg_tick_limit = val & 32'hF;
         CSR_OT_THR:      cfg_ot_thr     = val & 32'hFFF;
         CSR_OT_COUNT:    cfg_ot_count   = val & 32'hFF;
         CSR_OC_LIMIT:    cfg_oc_limit   = val & 32'hFFF;
         CSR_OC_COUNT:    cfg_oc_count   = val & 32'hFF;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int unsigned thr, input int unsigned ticks,
                             input int unsigned ot, input int unsigned otc,
                             input int unsigned oc, input int unsigned occ);
      wait_idle();
      write_csr(CSR_EMPTY_THR, thr);
      write_csr(CSR_EMPTY_TICKS, ticks);
      write_csr(CSR_OT_THR, ot);
      write_csr(CSR_OT_COUNT, otc);
      write_csr(CSR_OC_LIMIT, oc);
      write_csr(CSR_OC_COUNT, occ);
   endtask

   function automatic req_word_type sample(input int unsigned load, input int unsigned temp,
                                           input bit pre, input bit heat);
      req_word_type w;
      w.kind         = KIND_SAMPLE;
      w.load_mv      = load[MV_W-1:0];
      w.temp_mv      = temp[MV_W-1:0];
      w.preheat_done = pre;
      w.heater_on    = heat;
      return w;
   endfunction

   function automatic req_word_type tick_word();
      req_word_type w;
      w = sample($urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      w.kind = KIND_TICK;
      return w;
   endfunction

   function automatic int unsigned below(input int unsigned lim);
      return (lim == 0) ? $urandom_range(4095) : $urandom_range(lim - 1);
   endfunction

   function automatic int unsigned above(input int unsigned lim);
      return (lim >= 4095) ? $urandom_range(4095) : $urandom_range(4095, lim + 1);
   endfunction

   task automatic drive_sequences(input int count);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // low load run to raise the empty flag, then ticks
            len = $urandom_range(25, 45);
            repeat (len) send_word(sample(below(cfg_empty_thr), $urandom_range(4095),
                                          $urandom_range(19) != 0,
                                          1'($urandom_range(1))));
            sent += len;
            len = $urandom_range(1, 16);
            repeat (len) send_word(tick_word());
            sent += len;
         end else if (pick < 50) begin
            len = $urandom_range(1, 20);
            repeat (len) send_word(sample($urandom_range(4095), below(cfg_ot_thr),
                                          1'($urandom_range(1)), $urandom_range(4) != 0));
            sent += len;
         end else if (pick < 70) begin
            len = $urandom_range(1, 8);
            repeat (len) send_word(sample(above(cfg_oc_limit), $urandom_range(4095),
                                          1'($urandom_range(1)), 1'($urandom_range(1))));
            sent += len;
         end else begin
            len = $urandom_range(1, 5);
            repeat (len) begin
               if ($urandom_range(1)) send_word(tick_word());
               else send_word(sample($urandom_range(4095), $urandom_range(4095),
                                     1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            sent += len;
         end
      end
   endtask

   task automatic test_directed();
      send_word(sample(4095, 4095, 1'b0, 1'b1));      // before preheat
      send_word(tick_word());
      send_word(sample(0, 0, 1'b0, 1'b0));
      send_word(sample(0, 0, 1'b1, 1'b0));            // primes window with zero
      repeat (5) send_word(sample(4095, 4095, 1'b1, 1'b1));
      send_word(sample(2900, 4095, 1'b1, 1'b1));
      send_word(sample(2901, 4095, 1'b1, 1'b1));
      repeat (10) send_word(sample(1000, 691, 1'b1, 1'b0));
      send_word(sample(1000, 691, 1'b1, 1'b1));       // hot run over limit with heater on
      send_word(sample(1000, 692, 1'b1, 1'b1));
   endtask

   task automatic test_config_phases();
      set_config(EMPTY_THR_RESET, 32'(EMPTY_TICK_LIMIT_RESET), 32'(OT_THR_RESET),
                 32'(OT_COUNT_RESET), 32'(OC_LIMIT_RESET), 32'(OC_COUNT_RESET));
      drive_sequences(100);
      set_config(0, 0, 0, 0, 0, 0);
      drive_sequences(80);
      set_config(4095, 15, 4095, 255, 4095, 255);
      no_idle <= 1'b1;
      drive_sequences(100);
      no_idle <= 1'b0;
      set_config(3000, 0, 1500, 2, 2000, 0);    // first flagged tick shuts down
      stall_req <= stall_req + 1;
      drive_sequences(100);
      repeat (2) begin
         set_config($urandom_range(3000), $urandom_range(1, 15), $urandom_range(3000),
                    $urandom_range(20), $urandom_range(3000), $urandom_range(10));
         drive_sequences(60);
      end
   endtask

   task automatic test_long_empty_run();
      int n;
      set_config(4095, 15, 4095, 254, 0, $urandom_range(254));
      no_idle <= 1'b1;
      for (n = 0; n < 100; n++)
         send_word(sample($urandom_range(1, 4094), $urandom_range(4094), 1'b1,
                          (n > 30) && ($urandom_range(9) == 0)));
      repeat (4) send_word(tick_word());
      no_idle <= 1'b0;
   endtask

   initial begin
      reset_monitor();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_phases();
      test_long_empty_run();
      wait_idle();
      if (fail_count == 0 && rsp_due.size() == 0)
         $display("heater_load_protection_monitor_top regression: pass");
      else
         $display("heater_load_protection_monitor_top regression: fail");
      $finish;
   end

endmodule
